@@ src/nge_pkg.sv @@
// ----------------------------------------------------------------------------
// nge_pkg: shared types and constants of the next-greater-element engine
// Widths of the payload fields, the stack depth and the result record.
// ----------------------------------------------------------------------------
`default_nettype none

package nge_pkg;

   // Longest sequence that is tracked; later values are dropped (overflow).
   localparam int MAX_LENGTH = 32;
   localparam int IDX_W      = $clog2(MAX_LENGTH);
   localparam int COUNT_W    = IDX_W + 1;

   localparam int VALUE_W    = 32;
   localparam int POS_W      = 5;

   typedef logic signed [VALUE_W-1:0] value_type;
   typedef logic [POS_W-1:0]          pos_type;
   typedef logic [COUNT_W-1:0]        count_type;
   typedef logic [IDX_W-1:0]          idx_type;

   // One answer, without the last-result mark.
   typedef struct packed {
      pos_type   position;
      value_type greater_value;
      logic      found;
      logic      overflow;
   } result_type;

endpackage

`default_nettype wire

@@ src/nge_req_if.sv @@
// ----------------------------------------------------------------------------
// nge_req_if: input channel of the next-greater-element engine
// Valid/ready handshake carrying one sample per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface nge_req_if import nge_pkg::*; ();
   logic      valid;
   logic      ready;
   value_type sample_value;
   logic      end_of_sequence;

   modport source (output valid, output sample_value, output end_of_sequence,
                   input ready);
   modport sink   (input valid, input sample_value, input end_of_sequence,
                   output ready);
endinterface

`default_nettype wire

@@ src/nge_rsp_if.sv @@
// ----------------------------------------------------------------------------
// nge_rsp_if: result channel of the next-greater-element engine
// Valid/ready handshake carrying one answer per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface nge_rsp_if import nge_pkg::*; ();
   logic      valid;
   logic      ready;
   pos_type   position;
   value_type greater_value;
   logic      found;
   logic      overflow;
   logic      last_result;

   modport source (output valid, output position, output greater_value,
                   output found, output overflow, output last_result,
                   input ready);
   modport sink   (input valid, input position, input greater_value,
                   input found, input overflow, input last_result,
                   output ready);
endinterface

`default_nettype wire

@@ src/next_greater_element_stack.sv @@
// ----------------------------------------------------------------------------
// next_greater_element_stack: monotonic-stack next-greater-element engine
// Answers every position of a signed sequence with its next greater value.
// ----------------------------------------------------------------------------
// Each request transaction carries one signed 32-bit sample; end_of_sequence
// marks the last one. Samples get positions 0, 1, 2, ... and wait on a stack
// of MAX_LENGTH entries. A new sample pops every waiting entry with a strictly
// smaller value, one pop per cycle through a single signed comparator while
// the response side does not stall, and each pop yields one response
// (position, the new sample, found = 1). On the end mark, entries still
// waiting are flushed top-down with found = 0 and the position counter
// restarts. Samples past MAX_LENGTH in one sequence are dropped and answered
// with overflow = 1. last_result flags the final response of each request.
// A request is worked through in order: accept, pops, push, final hand-over;
// the end mark adds a flush of the waiting entries. A dropped sample goes
// from accept to the flush or the final hand-over. The request side is ready
// only between requests; a finished response waits in an output register
// and does not block the next request.
// ----------------------------------------------------------------------------
`default_nettype none

module next_greater_element_stack import nge_pkg::*; (
   input  wire       clock,
   input  wire       reset,
   nge_req_if.sink   req_chan,
   nge_rsp_if.source rsp_chan
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_CMP,    // pop smaller entries, then push the sample
      S_FLUSH,  // end of sequence: drain the stack
      S_DONE    // hand over the held answer as the last one
   } state_type;

   // stack storage, one read (top) and one write port
   pos_type   stk_pos [MAX_LENGTH];
   value_type stk_val [MAX_LENGTH];

   state_type  state_ff, state_in;
   count_type  cnt_ff, cnt_in;
   count_type  next_pos_ff, next_pos_in;
   value_type  val_ff, val_in;
   logic       eos_ff, eos_in;
   logic       ovf_ff, ovf_in;

   // one answer is held back until we know whether it is the last one
   logic       hold_valid_ff, hold_valid_in;
   result_type hold_ff, hold_in;

   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff, rsp_in;
   logic       rsp_last_ff, rsp_last_in;

   logic       push_en;
   idx_type    top_idx;
   pos_type    top_pos;
   value_type  top_val;
   logic       stack_empty;
   logic       slot_free;
   logic       pop_hit;

   assign req_chan.ready = (state_ff == S_IDLE);

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.position      = rsp_ff.position;
   assign rsp_chan.greater_value = rsp_ff.greater_value;
   assign rsp_chan.found         = rsp_ff.found;
   assign rsp_chan.overflow      = rsp_ff.overflow;
   assign rsp_chan.last_result   = rsp_last_ff;

   count_type top_cnt;
   assign top_cnt     = cnt_ff - count_type'(1);
   assign top_idx     = top_cnt[IDX_W-1:0];
   assign top_pos     = stk_pos[top_idx];
   assign top_val     = stk_val[top_idx];
   assign stack_empty = (cnt_ff == '0);
   assign slot_free   = !rsp_valid_ff || rsp_chan.ready;
   // the shared comparator
   assign pop_hit     = !stack_empty && (val_ff > top_val);

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      next_pos_in   = next_pos_ff;
      val_in        = val_ff;
      eos_in        = eos_ff;
      ovf_in        = ovf_ff;
      hold_valid_in = hold_valid_ff;
      hold_in       = hold_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_in        = rsp_ff;
      rsp_last_in   = rsp_last_ff;
      push_en       = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               val_in        = req_chan.sample_value;
               eos_in        = req_chan.end_of_sequence;
               ovf_in        = (next_pos_ff >= count_type'(MAX_LENGTH));
               hold_valid_in = 1'b0;
               if (next_pos_ff >= count_type'(MAX_LENGTH)) begin
                  state_in = req_chan.end_of_sequence ? S_FLUSH : S_DONE;
               end else begin
                  state_in = S_CMP;
               end
            end
         end

         S_CMP: begin
            if (pop_hit) begin
               // a previous held answer goes out first, not last
               if (!hold_valid_ff || slot_free) begin
                  if (hold_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = hold_ff;
                     rsp_last_in  = 1'b0;
                  end
                  hold_valid_in         = 1'b1;
                  hold_in.position      = top_pos;
                  hold_in.greater_value = val_ff;
                  hold_in.found         = 1'b1;
                  hold_in.overflow      = 1'b0;
                  cnt_in                = top_cnt;
               end
            end else begin
               push_en     = 1'b1;
               cnt_in      = cnt_ff + count_type'(1);
               next_pos_in = next_pos_ff + count_type'(1);
               state_in    = eos_ff ? S_FLUSH : S_DONE;
            end
         end

         S_FLUSH: begin
            if (!stack_empty) begin
               if (!hold_valid_ff || slot_free) begin
                  if (hold_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = hold_ff;
                     rsp_last_in  = 1'b0;
                  end
                  hold_valid_in         = 1'b1;
                  hold_in.position      = top_pos;
                  hold_in.greater_value = '0;
                  hold_in.found         = 1'b0;
                  hold_in.overflow      = ovf_ff;
                  cnt_in                = top_cnt;
               end
            end else begin
               next_pos_in = '0;
               state_in    = S_DONE;
            end
         end

         S_DONE: begin
            if (hold_valid_ff || ovf_ff) begin
               if (slot_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_last_in  = 1'b1;
                  if (hold_valid_ff) begin
                     rsp_in = hold_ff;
                  end else begin
                     // dropped sample with nothing to flush
                     rsp_in.position      = '0;
                     rsp_in.greater_value = '0;
                     rsp_in.found         = 1'b0;
                     rsp_in.overflow      = 1'b1;
                  end
                  hold_valid_in = 1'b0;
                  state_in      = S_IDLE;
               end
            end else begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cnt_ff        <= '0;
         next_pos_ff   <= '0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         next_pos_ff   <= next_pos_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      val_ff      <= val_in;
      eos_ff      <= eos_in;
      ovf_ff      <= ovf_in;
      hold_ff     <= hold_in;
      rsp_ff      <= rsp_in;
      rsp_last_ff <= rsp_last_in;
   end

   // push at the current count; the count stays below MAX_LENGTH here
   always_ff @(posedge clock) begin
      if (push_en) begin
         stk_pos[cnt_ff[IDX_W-1:0]] <= next_pos_ff[POS_W-1:0];
         stk_val[cnt_ff[IDX_W-1:0]] <= val_ff;
      end
   end

endmodule

`default_nettype wire

@@ test/nge_answer_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nge_answer_checker: answer predictor and comparator for the NGE engine
// Watches both channels, predicts each answer of every accepted sample with
// a private monotonic stack and compares the answers in order, per field.
// ----------------------------------------------------------------------------

module nge_answer_checker import nge_pkg::*; (
   input  logic clock,
   input  logic reset,
   nge_req_if   req_chan,
   nge_rsp_if   rsp_chan,
   output int   mismatch_count,
   output int   outstanding
);

   typedef struct packed {
      result_type answer;
      logic       last_result;
   } answer_type;

   pos_type    stack_pos [MAX_LENGTH];
   value_type  stack_val [MAX_LENGTH];
   int         stack_depth;
   int         seq_index;
   answer_type expected_answers[$];

   task automatic report_mismatch(string what);
      mismatch_count++;
      $display("%0t ns: answer mismatch: %s", $time, what);
   endtask

   function automatic answer_type make_answer(pos_type pos, value_type val,
                                              logic found, logic dropped);
      answer_type a;
      a.answer.position      = pos;
      a.answer.greater_value = val;
      a.answer.found         = found;
      a.answer.overflow      = dropped;
      a.last_result          = 1'b0;
      return a;
   endfunction

   // Runs one sample through the stack and queues the answers it causes.
   function automatic void predict_answers(value_type sample, logic closing);
      answer_type batch[$];
      logic       dropped;
      dropped = (seq_index >= MAX_LENGTH);
      if (!dropped) begin
         // equal values stay; only a strictly greater sample pops
         while (stack_depth > 0 && sample > stack_val[stack_depth-1]) begin
            stack_depth--;
            batch.push_back(make_answer(stack_pos[stack_depth], sample, 1'b1, 1'b0));
         end
         stack_pos[stack_depth] = pos_type'(seq_index);
         stack_val[stack_depth] = sample;
         stack_depth++;
         seq_index++;
      end
      if (closing) begin
         while (stack_depth > 0) begin
            stack_depth--;
            batch.push_back(make_answer(stack_pos[stack_depth], '0, 1'b0, dropped));
         end
         seq_index = 0;
      end
      if (dropped && batch.size() == 0)
         batch.push_back(make_answer('0, '0, 1'b0, 1'b1));
      if (batch.size() > 0)
         batch[batch.size()-1].last_result = 1'b1;
      foreach (batch[k])
         expected_answers.push_back(batch[k]);
   endfunction

   initial begin
      mismatch_count = 0;
      outstanding    = 0;
   end

   always @(posedge clock) begin
      answer_type want;
      if (reset) begin
         stack_depth = 0;
         seq_index   = 0;
         expected_answers.delete();
      end else begin
         // answers first: one leaving now cannot belong to a sample taken now
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_answers.size() == 0) begin
               report_mismatch($sformatf("unexpected answer for position %0d",
                                         rsp_chan.position));
            end else begin
               want = expected_answers.pop_front();
               if (rsp_chan.position !== want.answer.position)
                  report_mismatch($sformatf("position got %0d expected %0d",
                                            rsp_chan.position, want.answer.position));
               if (rsp_chan.greater_value !== want.answer.greater_value)
                  report_mismatch($sformatf("greater_value got %0d expected %0d",
                                            rsp_chan.greater_value,
                                            want.answer.greater_value));
               if (rsp_chan.found !== want.answer.found)
                  report_mismatch($sformatf("found got %b expected %b",
                                            rsp_chan.found, want.answer.found));
               if (rsp_chan.overflow !== want.answer.overflow)
                  report_mismatch($sformatf("overflow got %b expected %b",
                                            rsp_chan.overflow, want.answer.overflow));
               if (rsp_chan.last_result !== want.last_result)
                  report_mismatch($sformatf("last_result got %b expected %b",
                                            rsp_chan.last_result, want.last_result));
            end
         end
         if (req_chan.valid && req_chan.ready)
            predict_answers(req_chan.sample_value, req_chan.end_of_sequence);
      end
      outstanding <= expected_answers.size();
   end

endmodule

@@ test/tb_next_greater_element_stack.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_next_greater_element_stack: testbench top of the NGE engine
// Drives sample sequences and random answer-side backpressure; the checker
// beside the engine predicts and compares every answer transaction.
// ----------------------------------------------------------------------------

module tb_next_greater_element_stack import nge_pkg::*; ();

   // Worst case is far below this: ~160 samples, up to 32 answers each,
   // each answer held off by one answer-side stall at most.
   localparam int CYCLE_LIMIT   = 250000;
   localparam int DIRECTED_ITEMS = 14;
   localparam int RANDOM_ITEMS   = 110;
   localparam int DRAIN_CYCLES   = 40;   // stack flush tail plus margin

   // how the values of one random sequence are drawn
   typedef enum int {SHAPE_WIDE, SHAPE_NARROW, SHAPE_FALLING, SHAPE_RISING} shape_type;

   logic clock;
   logic reset;
   bit   idle_enabled;
   int   sent_items;
   int   cycle_count;
   int   mismatch_count;
   int   outstanding;

   nge_req_if req_chan();
   nge_rsp_if rsp_chan();

   next_greater_element_stack u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   nge_answer_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan),
      .rsp_chan       (rsp_chan),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   // 10 ns clock, low then high
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Global timeout: a hung handshake ends the run here.
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // One request transaction. Called at a rising edge; returns at the edge
   // where the sample was taken, with valid still high so a following call
   // can keep it up without a drop.
   task automatic send_sample(value_type sample, logic closing);
      if (idle_enabled && $urandom_range(0, 3) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_chan.valid           <= 1'b1;
      req_chan.sample_value    <= sample;
      req_chan.end_of_sequence <= closing;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      sent_items++;
   endtask

   // A whole sequence; the end mark rides on its last sample.
   task automatic send_sequence(int length, shape_type shape);
      value_type v;
      v = value_type'($urandom_range(0, 1 << 30));
      if (shape == SHAPE_RISING)
         v = -v;
      for (int k = 0; k < length; k++) begin
         case (shape)
            SHAPE_WIDE:    v = value_type'($urandom);
            SHAPE_NARROW:  v = value_type'($urandom_range(0, 16)) - 8;   // many ties
            SHAPE_FALLING: v = v - value_type'($urandom_range(0, 3));    // deep stack
            default:       v = v + value_type'($urandom_range(0, 3));    // pops unless a tie
         endcase
         send_sample(v, k == length - 1);
      end
   endtask

   // Answer side: ready drops in random bursts while idling is on.
   initial begin
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (idle_enabled && $urandom_range(0, 2) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   end

   initial begin
      int        length;
      int        pick;
      shape_type shape;

      reset                    <= 1'b1;
      req_chan.valid           <= 1'b0;
      req_chan.sample_value    <= '0;
      req_chan.end_of_sequence <= 1'b0;
      idle_enabled = 1'b1;
      sent_items   = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed ---
      // extremes of the value range, a tie (-1, -1) and a closing pop
      send_sample(32'sh8000_0000, 1'b0);
      send_sample(32'sh7FFF_FFFF, 1'b0);
      send_sample(32'sh0000_0000, 1'b0);   // pops nothing: no answer
      send_sample(-32'sd1, 1'b0);
      send_sample(-32'sd1, 1'b0);
      send_sample(32'sd5, 1'b1);
      // one-sample sequence: flushed unanswered right away
      send_sample(32'sd7, 1'b1);
      // falling run, all flushed top-down on the end mark
      send_sample(32'sd3, 1'b0);
      send_sample(32'sd2, 1'b0);
      send_sample(32'sd1, 1'b1);
      // ties stay waiting until a strictly greater value comes
      send_sample(32'sd4, 1'b0);
      send_sample(32'sd4, 1'b0);
      send_sample(32'sd4, 1'b0);
      send_sample(32'sd9, 1'b1);

      // hold the sender until the engine has answered everything
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);

      // --- random ---
      // Past the stack depth: a full falling stack, dropped samples with
      // overflow, then a 32-entry flush marked as overflow.
      send_sequence(MAX_LENGTH + 3, SHAPE_FALLING);

      while (sent_items < DIRECTED_ITEMS + RANDOM_ITEMS) begin
         // last stretch runs without idling on either side
         if (sent_items >= DIRECTED_ITEMS + RANDOM_ITEMS - 25)
            idle_enabled = 1'b0;
         pick = $urandom_range(0, 9);
         if (pick == 0)
            length = $urandom_range(MAX_LENGTH + 1, MAX_LENGTH + 4);
         else if (pick <= 2)
            length = $urandom_range(12, MAX_LENGTH - 1);
         else
            length = $urandom_range(1, 8);
         shape = shape_type'($urandom_range(0, 3));
         send_sequence(length, shape);
      end
      req_chan.valid <= 1'b0;
      idle_enabled = 1'b0;

      // drain: outstanding is a registered copy of the checker's queue size
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && outstanding == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
